>>> hw/rtl/sfpt_pkg.sv
// ----------------------------------------------------------------------------
// sfpt_pkg
// Request, result and table entry types plus operation and status codes for
// the slot flow priority table.
// ----------------------------------------------------------------------------
package sfpt_pkg;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_FIND  = 2'd1;
    localparam logic [1:0] ACT_COUNT = 2'd2;

    localparam logic [1:0] ST_PRESENT = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_ADDED   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] flow_key;
        logic [7:0]  frame_handle;
        logic [7:0]  slot_number;
        logic [7:0]  channel_offset;
        logic [7:0]  rank;
        logic        schedule_locked;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] best_flow;
        logic [5:0]  match_count;
    } t_result;

    typedef struct packed {
        logic [7:0]  frame;
        logic [7:0]  slot;
        logic [7:0]  chan;
        logic [7:0]  prio;
        logic [15:0] flow;
    } t_entry;

endpackage

>>> hw/rtl/sfpt_store.sv
// ----------------------------------------------------------------------------
// sfpt_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfpt_store #(
    parameter int TABLE_ENTRIES = 32,
    parameter int IDX_W         = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  sfpt_pkg::t_entry     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output sfpt_pkg::t_entry     o_rd_data
);
    import sfpt_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/sfpt_scan.sv
// ----------------------------------------------------------------------------
// sfpt_scan
// Scan sequencer: walks the filled entries one per cycle through a single
// compare unit, writes back an added or updated entry, then gives the result.
// ----------------------------------------------------------------------------
module sfpt_scan #(
    parameter int TABLE_ENTRIES = 32,
    parameter int IDX_W         = 5,
    parameter int CNT_W         = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sfpt_pkg::t_request   i_req,
    output logic                 o_done,
    output sfpt_pkg::t_result    o_res,
    output logic                 o_rd_en,
    output logic [IDX_W-1:0]     o_rd_addr,
    input  sfpt_pkg::t_entry     i_rd_data,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_addr,
    output sfpt_pkg::t_entry     o_wr_data
);
    import sfpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    logic [1:0]       r_state, n_state;
    t_request         r_req, n_req;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_eval_vld, n_eval_vld;
    logic [IDX_W-1:0] r_eval_idx, n_eval_idx;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [1:0]       r_status, n_status;
    logic             r_found, n_found;
    logic [7:0]       r_best_prio, n_best_prio;
    logic [15:0]      r_best_flow, n_best_flow;
    logic [5:0]       r_count, n_count;

    logic key_hit, slot_hit, flow_hit;

    // the shared compare unit
    assign key_hit  = (i_rd_data.frame == r_req.frame_handle) &&
                      (i_rd_data.slot == r_req.slot_number) &&
                      (i_rd_data.chan == r_req.channel_offset) &&
                      (i_rd_data.flow == r_req.flow_key);
    assign slot_hit = (i_rd_data.frame == r_req.frame_handle) &&
                      (i_rd_data.slot == r_req.slot_number);
    assign flow_hit = (i_rd_data.flow == r_req.flow_key);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_fill      = r_fill;
        n_issue     = r_issue;
        n_eval_vld  = r_eval_vld;
        n_eval_idx  = r_eval_idx;
        n_hit_idx   = r_hit_idx;
        n_status    = r_status;
        n_found     = r_found;
        n_best_prio = r_best_prio;
        n_best_flow = r_best_flow;
        n_count     = r_count;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_issue[IDX_W-1:0];
        o_wr_en     = 1'b0;
        o_done      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req       = i_req;
                    n_issue     = '0;
                    n_eval_vld  = 1'b0;
                    n_status    = ST_PRESENT;
                    n_found     = 1'b0;
                    n_best_prio = '0;
                    n_best_flow = '0;
                    n_count     = '0;
                    if (i_req.action == ACT_ADD || i_req.action == ACT_COUNT ||
                        (i_req.action == ACT_FIND && !i_req.schedule_locked)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                n_eval_vld = 1'b0;
                if (r_issue < r_fill) begin
                    o_rd_en    = 1'b1;
                    n_issue    = r_issue + CNT_W'(1);
                    n_eval_vld = 1'b1;
                    n_eval_idx = r_issue[IDX_W-1:0];
                end else if (!r_eval_vld) begin
                    // all entries seen
                    n_state = S_DONE;
                    if (r_req.action == ACT_ADD) begin
                        n_hit_idx = r_fill[IDX_W-1:0];
                        n_status  = (r_fill >= FULL_CNT) ? ST_FULL : ST_ADDED;
                    end
                end
                if (r_eval_vld) begin
                    case (r_req.action)
                        ACT_ADD: begin
                            // first matching entry ends the scan
                            if (key_hit) begin
                                n_state    = S_DONE;
                                n_eval_vld = 1'b0;
                                n_hit_idx  = r_eval_idx;
                                n_status   = (i_rd_data.prio == r_req.rank) ?
                                             ST_PRESENT : ST_UPDATED;
                            end
                        end
                        ACT_FIND: begin
                            if (slot_hit && (!r_found || i_rd_data.prio < r_best_prio)) begin
                                n_found     = 1'b1;
                                n_best_prio = i_rd_data.prio;
                                n_best_flow = i_rd_data.flow;
                            end
                        end
                        ACT_COUNT: begin
                            if (flow_hit) begin
                                n_count = r_count + 6'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                if (r_req.action == ACT_ADD &&
                    (r_status == ST_UPDATED || r_status == ST_ADDED)) begin
                    o_wr_en = 1'b1;
                end
                if (r_req.action == ACT_ADD && r_status == ST_ADDED) begin
                    n_fill = r_fill + CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // an update rewrites the whole entry: its key equals the request's
    assign o_wr_addr = r_hit_idx;
    assign o_wr_data = '{frame: r_req.frame_handle, slot: r_req.slot_number,
                         chan: r_req.channel_offset, prio: r_req.rank,
                         flow: r_req.flow_key};

    assign o_res = '{status: r_status, found: r_found, best_flow: r_best_flow,
                     match_count: r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_eval_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_eval_vld <= n_eval_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_issue     <= n_issue;
        r_eval_idx  <= n_eval_idx;
        r_hit_idx   <= n_hit_idx;
        r_status    <= n_status;
        r_found     <= n_found;
        r_best_prio <= n_best_prio;
        r_best_flow <= n_best_flow;
        r_count     <= n_count;
    end

endmodule

>>> hw/rtl/slot_flow_priority_table.sv
// ----------------------------------------------------------------------------
// slot_flow_priority_table
// Append-only table of schedule flow entries with add/update, best-flow find
// and flow count requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is issued. Add, count and unlocked find requests read the
// filled entries one per cycle through the table's single read port, so busy
// stays high for the whole scan and the next request can be taken only once
// busy has fallen; an add that hits an existing entry stops at that entry,
// and a locked find or an unused action holds busy for a single cycle. The
// result appears on o_res for one cycle with o_done high, in the cycle busy
// falls, and must be captured then: the block cannot be stalled on the
// result side. Table contents are not cleared by reset; only the fill count
// is, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_flow_priority_table #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sfpt_pkg::t_request   i_req,
    output logic                 o_done,
    output sfpt_pkg::t_result    o_res
);
    import sfpt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic             r_busy;
    logic             r_done;
    t_result          r_res;

    logic             accept;
    logic             scan_done;
    t_result          scan_res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    assign accept = start && !r_busy;

    sfpt_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_req     (i_req),
        .o_done    (scan_done),
        .o_res     (scan_res),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    sfpt_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= scan_done;
            if (scan_done) begin
                r_busy <= 1'b0;
            end else if (accept) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            r_res <= scan_res;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> bench/slot_flow_priority_table_check.sv
// ----------------------------------------------------------------------------
// slot_flow_priority_table_check
// Watches the request and result channels of the slot flow priority table,
// keeps a shadow of the flow table, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module slot_flow_priority_table_check #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  sfpt_pkg::t_request   i_req,
    input  logic                 i_done,
    input  sfpt_pkg::t_result    i_res,
    output int                   o_fail_count,
    output int                   o_pending
);
    import sfpt_pkg::*;

    // Starting point of the best-rank search, above any 8-bit priority.
    localparam int NO_RANK = 1000;

    t_entry  shadow_table [TABLE_ENTRIES];
    int      table_fill;
    t_result expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        table_fill   = 0;
    end

    // Applies one request to the shadow table and returns its result.
    function automatic t_result apply_request(input t_request r);
        t_result y;
        int      hit;
        int      best_rank;
        int      hits;
        y         = '0;
        hit       = -1;
        best_rank = NO_RANK;
        hits      = 0;
        case (r.action)
            ACT_ADD: begin
                // first entry in table order wins
                for (int i = 0; i < table_fill; i++) begin
                    if (hit < 0 && shadow_table[i].frame == r.frame_handle &&
                        shadow_table[i].slot == r.slot_number &&
                        shadow_table[i].chan == r.channel_offset &&
                        shadow_table[i].flow == r.flow_key)
                        hit = i;
                end
                if (hit >= 0) begin
                    if (shadow_table[hit].prio == r.rank) begin
                        y.status = ST_PRESENT;
                    end else begin
                        shadow_table[hit].prio = r.rank;
                        y.status = ST_UPDATED;
                    end
                end else if (table_fill >= TABLE_ENTRIES) begin
                    y.status = ST_FULL;
                end else begin
                    shadow_table[table_fill] = '{frame: r.frame_handle, slot: r.slot_number,
                                                 chan: r.channel_offset, prio: r.rank,
                                                 flow: r.flow_key};
                    table_fill++;
                    y.status = ST_ADDED;
                end
            end
            ACT_FIND: begin
                if (!r.schedule_locked) begin
                    // strict compare keeps the earliest entry on a tie
                    for (int i = 0; i < table_fill; i++) begin
                        if (shadow_table[i].frame == r.frame_handle &&
                            shadow_table[i].slot == r.slot_number &&
                            int'(shadow_table[i].prio) < best_rank) begin
                            best_rank   = int'(shadow_table[i].prio);
                            y.best_flow = shadow_table[i].flow;
                            y.found     = 1'b1;
                        end
                    end
                end
            end
            ACT_COUNT: begin
                for (int i = 0; i < table_fill; i++) begin
                    if (shadow_table[i].flow == r.flow_key)
                        hits++;
                end
                y.match_count = hits[5:0];
            end
            default: begin
            end
        endcase
        return y;
    endfunction

    task automatic compare_result(input t_result want, input t_result got);
        if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            o_fail_count++;
        end
        if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
            o_fail_count++;
        end
        if (got.best_flow !== want.best_flow) begin
            $display("%0t: best_flow mismatch, expected %h, actual %h",
                     $time, want.best_flow, got.best_flow);
            o_fail_count++;
        end
        if (got.match_count !== want.match_count) begin
            $display("%0t: match_count mismatch, expected %0d, actual %0d",
                     $time, want.match_count, got.match_count);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_fill = 0;
            expected_results.delete();
        end else begin
            // a result belongs to an earlier request, so retire before pushing
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_res);
                    o_fail_count++;
                end else begin
                    compare_result(expected_results.pop_front(), i_res);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_request(i_req));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> bench/slot_flow_priority_table_test.sv
// ----------------------------------------------------------------------------
// slot_flow_priority_table_test
// Drives add, find, count and unused requests into the slot flow priority
// table: a directed opening on the corner cases, then random requests built
// mostly around keys already sent. The checker beside the block judges every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module slot_flow_priority_table_test;
    import sfpt_pkg::*;

    localparam int         TABLE_ENTRIES   = 32;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;
    localparam int         RANDOM_REQUESTS = 1530;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         DRAIN_CYCLES    = 40;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    t_request req;
    t_result  res;
    int       fail_count;
    int       pending;
    int       stall_cycles = 0;
    bit       idling_on;
    t_entry   key_pool [$];

    slot_flow_priority_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (req),
        .o_done (done),
        .o_res  (res)
    );

    slot_flow_priority_table_check #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req),
        .i_done      (done),
        .i_res       (res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run when neither a request nor a result moves for too long.
    always @(posedge clk) begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_request make_request(input logic [1:0] action,
                                              input logic [15:0] flow,
                                              input logic [7:0] frame,
                                              input logic [7:0] slot,
                                              input logic [7:0] chan,
                                              input logic [7:0] rank,
                                              input logic locked);
        t_request r;
        r.action          = action;
        r.flow_key        = flow;
        r.frame_handle    = frame;
        r.slot_number     = slot;
        r.channel_offset  = chan;
        r.rank            = rank;
        r.schedule_locked = locked;
        return r;
    endfunction

    // Half the time narrowed to two bits so keys and ranks collide.
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(1))
            v = {6'd0, v[1:0]};
        return v;
    endfunction

    function automatic logic [15:0] pick_flow();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(1))
            v = {14'd0, v[1:0]};
        return v;
    endfunction

    function automatic t_request random_request();
        t_request r;
        t_entry   k;
        int       sel;
        int       idx;
        r.flow_key        = 16'($urandom);
        r.frame_handle    = 8'($urandom);
        r.slot_number     = 8'($urandom);
        r.channel_offset  = 8'($urandom);
        r.rank            = 8'($urandom);
        r.schedule_locked = ($urandom_range(6) == 0);
        sel = $urandom_range(99);
        idx = (key_pool.size() > 0) ? $urandom_range(key_pool.size() - 1) : 0;
        if (key_pool.size() > 0)
            k = key_pool[idx];
        if (sel < 45) begin
            r.action = ACT_ADD;
            if (key_pool.size() == 0 || $urandom_range(2) == 0) begin
                r.frame_handle   = pick_byte();
                r.slot_number    = pick_byte();
                r.channel_offset = pick_byte();
                r.flow_key       = pick_flow();
                r.rank           = pick_byte();
                // a few keys beyond capacity keep the full case coming
                if (key_pool.size() < TABLE_ENTRIES + 8)
                    key_pool.push_back('{frame: r.frame_handle, slot: r.slot_number,
                                         chan: r.channel_offset, prio: r.rank,
                                         flow: r.flow_key});
            end else begin
                r.frame_handle   = k.frame;
                r.slot_number    = k.slot;
                r.channel_offset = k.chan;
                r.flow_key       = k.flow;
                r.rank           = $urandom_range(1) ? k.prio : pick_byte();
                key_pool[idx].prio = r.rank;
            end
        end else if (sel < 75) begin
            r.action = ACT_FIND;
            if (key_pool.size() > 0 && $urandom_range(4) != 0) begin
                r.frame_handle = k.frame;
                r.slot_number  = k.slot;
            end
        end else if (sel < 95) begin
            r.action = ACT_COUNT;
            r.flow_key = (key_pool.size() > 0 && $urandom_range(3) != 0) ? k.flow
                                                                          : pick_flow();
        end else begin
            r.action = ACT_UNUSED;
        end
        return r;
    endfunction

    // Presents one request and returns at the edge that takes it.
    task automatic send_request(input t_request r);
        @(negedge clk);
        while (idling_on && $urandom_range(99) < 28) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        idling_on = 1'b1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        send_request(make_request(ACT_COUNT, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_FIND, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        // added, present, then priority updated
        send_request(make_request(ACT_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        send_request(make_request(ACT_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0));
        send_request(make_request(ACT_ADD, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        // two entries on one slot with equal priority: earliest wins
        send_request(make_request(ACT_ADD, 16'h1111, 8'hff, 8'hff, 8'h00, 8'h10, 1'b0));
        send_request(make_request(ACT_ADD, 16'h2222, 8'hff, 8'hff, 8'h01, 8'h10, 1'b0));
        send_request(make_request(ACT_FIND, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_request(ACT_FIND, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_request(ACT_COUNT, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_request(ACT_COUNT, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_UNUSED, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_request(ACT_UNUSED, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        // lower priority on the same slot takes over, then a tie at zero
        send_request(make_request(ACT_ADD, 16'h2222, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_FIND, 16'h0000, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_ADD, 16'hffff, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0));
        send_request(make_request(ACT_FIND, 16'h0000, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_COUNT, 16'h2222, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_request(ACT_FIND, 16'h0000, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idling_on = !(n >= 600 && n < 900);
            if (n % 250 == 125)
                wait_for_results();
            send_request(random_request());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> slot_flow_priority_table.f
hw/rtl/sfpt_pkg.sv
hw/rtl/sfpt_store.sv
hw/rtl/sfpt_scan.sv
hw/rtl/slot_flow_priority_table.sv
bench/slot_flow_priority_table_check.sv
bench/slot_flow_priority_table_test.sv
